// ----- hw/rtl/pal_pkg.sv -----
package pal_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 6;
  localparam int CAP_W     = 6;
  localparam int CAP_RST   = 32;

  typedef enum logic [1:0] {
    OP_INS_AT   = 2'd0,
    OP_INS_HEAD = 2'd1,
    OP_INS_TAIL = 2'd2,
    OP_DEL_AT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_UP   = 2'd1,
    CELL_DOWN = 2'd2
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t         mode;
    logic [POS_W-1:0]   pos;
    logic [WORD_W-1:0]  ins_word;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/pal_cell.sv -----
module pal_cell import pal_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [WORD_W-1:0] left_word,
  input  logic [WORD_W-1:0] right_word,
  output logic [WORD_W-1:0] word
);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    unique case (ctrl.mode)
      CELL_UP: begin
        if (IDX > int'(ctrl.pos)) begin
          word_nxt = left_word;
        end else if (IDX == int'(ctrl.pos)) begin
          word_nxt = ctrl.ins_word;
        end
      end
      CELL_DOWN: begin
        if (IDX >= int'(ctrl.pos)) begin
          word_nxt = right_word;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ----- hw/rtl/positional_array_list.sv -----
// Bounded ordered list of signed 32-bit words held in a row of cells.
// Input channel: an op, a position and an insert word are taken at a rising
// edge where start is high and busy is low. busy is always low, so one word
// may be issued every cycle.
// Ops: insert at position, insert at head, insert at tail, delete at position.
// Cells at or above the position update at once, on insert from the left (the
// insert word at the position), on delete from the right, when the op is accepted.
// Result channel: out_strobe is high for exactly one cycle, in the cycle after
// the accepting edge, with status, removed word, entry count and flags.
// The receiver cannot stall; each result is valid for that one cycle only.
// Config: cfg_capacity_we writes the capacity, clamped to 1..DEPTH on use.
// Write it only while no op is in flight.
// Reset (rst_n low, synchronous) empties the list and sets capacity to 32;
// cell contents are undefined until written.
module positional_array_list import pal_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_capacity_we,
  input  logic [CAP_W-1:0]         cfg_capacity,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_op,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [WORD_W-1:0] in_insert_value,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic signed [WORD_W-1:0] out_removed_value,
  output logic [POS_W-1:0]         out_entry_count,
  output logic                     out_empty_flag,
  output logic                     out_full_flag
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CAP_W-1:0]  cap_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [CW-1:0]     eff_cap;
  logic [CW-1:0]     ins_at;
  logic              full_now;
  status_t           status_nxt;
  logic [WORD_W-1:0] removed_nxt;
  cell_ctrl_t        ctrl;
  logic [WORD_W-1:0] words [DEPTH];

  logic              strobe_r;
  status_t           status_r;
  logic [WORD_W-1:0] removed_r;
  logic [CW-1:0]     count_out_r;
  logic              empty_r;
  logic              full_r;

  assign busy = 1'b0;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (int'(cap_r) > DEPTH) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap_r);
    end
  end

  assign full_now = (count_r >= eff_cap);

  always_comb begin
    unique case (op_t'(in_op))
      OP_INS_AT:   ins_at = CW'(in_position);
      OP_INS_HEAD: ins_at = '0;
      OP_INS_TAIL: ins_at = count_r;
      default:     ins_at = CW'(in_position);
    endcase
  end

  always_comb begin
    status_nxt    = ST_OK;
    count_nxt     = count_r;
    ctrl.mode     = CELL_HOLD;
    ctrl.pos      = in_position;
    ctrl.ins_word = in_insert_value;
    if (op_t'(in_op) == OP_DEL_AT) begin
      priority if (count_r == '0) begin
        status_nxt = ST_EMPTY;
      end else if (int'(in_position) >= int'(count_r)) begin
        status_nxt = ST_BADPOS;
      end else begin
        ctrl.mode = CELL_DOWN;
        count_nxt = count_r - CW'(1);
      end
    end else begin
      priority if (full_now) begin
        status_nxt = ST_FULL;
      end else if (op_t'(in_op) == OP_INS_AT && int'(in_position) > int'(count_r)) begin
        status_nxt = ST_BADPOS;
      end else begin
        ctrl.mode = CELL_UP;
        ctrl.pos  = POS_W'(ins_at);
        count_nxt = count_r + CW'(1);
      end
    end
    if (!(start && !busy)) begin
      ctrl.mode = CELL_HOLD;
      count_nxt = count_r;
    end
  end

  always_comb begin
    removed_nxt = '0;
    if (op_t'(in_op) == OP_DEL_AT && status_nxt == ST_OK) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (int'(in_position) == i) begin
          removed_nxt = words[i];
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = in_insert_value;
    end else begin : g_mid_l
      assign left_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = words[g];
    end else begin : g_mid_r
      assign right_w = words[g+1];
    end
    pal_cell #(
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_W'(CAP_RST);
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      if (cfg_capacity_we) begin
        cap_r <= cfg_capacity;
      end
      count_r  <= count_nxt;
      strobe_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    removed_r   <= removed_nxt;
    count_out_r <= count_nxt;
    empty_r     <= (count_nxt == '0);
    full_r      <= (count_nxt >= eff_cap);
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_entry_count   = POS_W'(count_out_r);
  assign out_empty_flag    = empty_r;
  assign out_full_flag     = full_r;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import pal_pkg::*;

  localparam int ITEM_TOTAL  = 1400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 4;

  typedef enum logic [1:0] {
    K_OP,
    K_CAP,
    K_QUIESCE,
    K_GAP
  } word_kind_t;

  typedef struct {
    word_kind_t               kind;
    op_t                      op;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] value;
    logic [CAP_W-1:0]         cap;
    int                       gap_pct;
  } list_word_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] removed;
    logic [POS_W-1:0]         count;
    logic                     empty;
    logic                     full;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_capacity_we = 1'b0;
  logic [CAP_W-1:0]         cfg_capacity = '0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_op = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [WORD_W-1:0] in_insert_value = '0;
  logic                     out_strobe;
  logic [1:0]               out_status;
  logic signed [WORD_W-1:0] out_removed_value;
  logic [POS_W-1:0]         out_entry_count;
  logic                     out_empty_flag;
  logic                     out_full_flag;

  list_word_t   pending_words[$];
  list_result_t expected_results[$];

  logic signed [WORD_W-1:0] shadow_cells [DEPTH_DEF];
  int                       shadow_fill = 0;
  logic [CAP_W-1:0]         shadow_cap = CAP_W'(CAP_RST);

  int sender_gap_pct = 0;
  int ops_issued = 0;
  int results_seen = 0;
  int cap_writes = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  positional_array_list dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_capacity_we  (cfg_capacity_we),
    .cfg_capacity     (cfg_capacity),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_position      (in_position),
    .in_insert_value  (in_insert_value),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_entry_count  (out_entry_count),
    .out_empty_flag   (out_empty_flag),
    .out_full_flag    (out_full_flag)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic apply_list_op(input op_t op, input logic [POS_W-1:0] pos,
                               input logic signed [WORD_W-1:0] value);
    list_result_t r;
    int at;
    int limit;
    limit = (shadow_cap < 1) ? 1 : (shadow_cap > DEPTH_DEF) ? DEPTH_DEF : int'(shadow_cap);
    r.status = ST_OK;
    r.removed = '0;
    if (op == OP_DEL_AT) begin
      if (shadow_fill == 0) begin
        r.status = ST_EMPTY;
      end else if (int'(pos) >= shadow_fill) begin
        r.status = ST_BADPOS;
      end else begin
        r.removed = shadow_cells[pos];
        for (int i = int'(pos); i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i + 1];
        shadow_fill--;
      end
    end else begin
      at = (op == OP_INS_HEAD) ? 0 : (op == OP_INS_TAIL) ? shadow_fill : int'(pos);
      if (shadow_fill >= limit) begin
        r.status = ST_FULL;
      end else if (at > shadow_fill) begin
        r.status = ST_BADPOS;
      end else begin
        for (int i = shadow_fill; i > at; i--) shadow_cells[i] = shadow_cells[i - 1];
        shadow_cells[at] = value;
        shadow_fill++;
      end
    end
    r.count = POS_W'(shadow_fill);
    r.empty = (shadow_fill == 0);
    r.full  = (shadow_fill >= limit);
    expected_results.push_back(r);
  endtask

  task automatic add_op(input op_t op, input int pos, input logic signed [WORD_W-1:0] value);
    list_word_t w;
    w.kind = K_OP;
    w.op = op;
    w.pos = POS_W'(pos);
    w.value = value;
    w.cap = '0;
    w.gap_pct = 0;
    pending_words.push_back(w);
  endtask

  task automatic add_ctrl(input word_kind_t kind, input int arg);
    list_word_t w;
    w.kind = kind;
    w.op = OP_INS_AT;
    w.pos = '0;
    w.value = '0;
    w.cap = CAP_W'(arg);
    w.gap_pct = arg;
    pending_words.push_back(w);
  endtask

  function automatic logic signed [WORD_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic int random_pos();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 3);
      8: return $urandom_range(0, 63);
      9: return $urandom_range(24, 32);
      default: return $urandom_range(0, 32);
    endcase
  endfunction

  function automatic int random_cap();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 32;
      4: return 63;
      default: return $urandom_range(0, 63);
    endcase
  endfunction

  // drive words; predict on every accepted one
  always @(posedge clk) begin : drive_words
    list_word_t w;
    logic nx_start;
    logic nx_we;
    nx_start = 1'b0;
    nx_we = 1'b0;
    if (rst_n) begin
      if (cfg_capacity_we) shadow_cap = cfg_capacity;
      if (start && !busy) begin
        apply_list_op(op_t'(in_op), in_position, in_insert_value);
        ops_issued++;
      end
      if (start && busy) begin
        nx_start = 1'b1;
      end else if (pending_words.size() != 0) begin
        w = pending_words[0];
        case (w.kind)
          K_GAP: begin
            sender_gap_pct = w.gap_pct;
            void'(pending_words.pop_front());
          end
          K_OP: begin
            if ($urandom_range(99) >= sender_gap_pct) begin
              in_op <= w.op;
              in_position <= w.pos;
              in_insert_value <= w.value;
              nx_start = 1'b1;
              void'(pending_words.pop_front());
            end
          end
          default: begin
            // hold until every expected word has come back
            if (expected_results.size() == 0 && !cfg_capacity_we) begin
              if (w.kind == K_CAP) begin
                cfg_capacity <= w.cap;
                nx_we = 1'b1;
                cap_writes++;
              end
              void'(pending_words.pop_front());
            end
          end
        endcase
      end
    end
    start <= nx_start;
    cfg_capacity_we <= nx_we;
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_results.pop_front();
        status_tally[want.status]++;
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_removed_value !== want.removed)
          report_mismatch($sformatf("removed got %0d want %0d", out_removed_value, want.removed));
        if (out_entry_count !== want.count)
          report_mismatch($sformatf("count got %0d want %0d", out_entry_count, want.count));
        if (out_empty_flag !== want.empty)
          report_mismatch($sformatf("empty got %0b want %0b", out_empty_flag, want.empty));
        if (out_full_flag !== want.full)
          report_mismatch($sformatf("full got %0b want %0b", out_full_flag, want.full));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL positional_array_list");
      $finish;
    end
  end

  initial begin : stimulus
    int gaps [3];
    int made;
    int seg_len;
    int seg_mode;
    int del_pct;
    gaps = '{12, 71, 0};

    add_ctrl(K_GAP, 0);
    add_op(OP_DEL_AT, 0, 0);
    add_op(OP_DEL_AT, 63, -1);
    add_op(OP_INS_AT, 1, 5);
    add_op(OP_INS_AT, 0, 32'sh7fffffff);
    add_op(OP_INS_HEAD, 63, 32'sh80000000);
    add_op(OP_INS_TAIL, 63, -1);
    add_op(OP_INS_AT, 3, 0);
    add_op(OP_INS_AT, 2, 32'sh5a5a5a5a);
    add_op(OP_INS_AT, 6, 1);
    add_op(OP_INS_AT, 32, 1);
    add_op(OP_INS_AT, 63, 1);
    add_op(OP_DEL_AT, 5, 0);
    add_op(OP_DEL_AT, 4, -1);
    add_op(OP_DEL_AT, 0, 0);
    add_ctrl(K_CAP, 0);
    add_op(OP_INS_TAIL, 0, 7);
    add_op(OP_INS_AT, 0, 8);
    add_op(OP_INS_AT, 40, 9);
    add_op(OP_DEL_AT, 1, 0);
    add_op(OP_DEL_AT, 0, 0);
    add_op(OP_DEL_AT, 0, 0);
    add_op(OP_INS_HEAD, 0, 32'sh0000ffff);
    add_op(OP_INS_TAIL, 0, 32'shffff0000);
    add_ctrl(K_CAP, 63);
    add_op(OP_INS_AT, 1, 32'sh12345678);
    add_ctrl(K_QUIESCE, 0);

    for (int ph = 0; ph < 3; ph++) begin
      add_ctrl(K_GAP, gaps[ph]);
      made = 0;
      while (made < ITEM_TOTAL / 3) begin
        if ($urandom_range(0, 3) == 0) add_ctrl(K_CAP, random_cap());
        if ($urandom_range(0, 9) == 0) add_ctrl(K_QUIESCE, 0);
        seg_len = $urandom_range(20, 60);
        seg_mode = $urandom_range(0, 2);
        del_pct = (seg_mode == 0) ? 20 : (seg_mode == 1) ? 80 : 50;
        for (int k = 0; k < seg_len; k++) begin
          if ($urandom_range(0, 99) < del_pct)
            add_op(OP_DEL_AT, random_pos(), random_value());
          else
            add_op(op_t'($urandom_range(0, 2)), random_pos(), random_value());
        end
        made += seg_len;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", expected_results.size()));

    $display("covered %0d list ops, %0d results, %0d capacity writes, sender gaps 12/71/0 pct",
             ops_issued, results_seen, cap_writes);
    $display("status mix: ok %0d, full %0d, empty %0d, bad position %0d",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
             status_tally[ST_BADPOS]);
    if (mismatches == 0) begin
      $display("PASS positional_array_list");
    end else begin
      $display("FAIL positional_array_list");
    end
    $finish;
  end

endmodule
